[hdl/svaw_pkg.sv]
// Shared types and constants of the strided view address walker.
`default_nettype none
package svaw_pkg;

  localparam int FLAT_W     = 32;
  localparam int SRC_W      = 32;
  localparam int BASE_W     = 24;
  localparam int RANK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_RANK     = 3'd0,
    REG_AXIS_EXTENTS  = 3'd1,
    REG_AXIS_STEPS    = 3'd2,
    REG_BASE_OFFSET   = 3'd3,
    REG_WINDOW_ENABLE = 3'd4,
    REG_WINDOW_BEGIN  = 3'd5,
    REG_WINDOW_END    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [FLAT_W-1:0] flat;
    logic              fill;
    logic              last;
  } svaw_meta_t;

endpackage
`default_nettype wire

[hdl/strided_view_address_walker_unit.sv]
// Top level of the strided view address walker: configuration registers and datapath.
// A step item passes the s1, product and result registers in turn to the outputs.
// Throughput: one item per cycle; the only limit is the result register being stalled.
// A step over an empty view (an axis in use of extent zero) produces no element.
// Reset (synchronous, rst_n low) clears the configuration and control registers, empties
// the pipeline and marks the walk as not started, so the first step begins at element zero.
`default_nettype none
module strided_view_address_walker_unit #(
  parameter int MAX_AXES  = 4,
  parameter int AXIS_BITS = 13
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [svaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [svaw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_restart_walk,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [svaw_pkg::FLAT_W-1:0]              out_element_number,
  output logic [svaw_pkg::SRC_W-1:0]               out_source_element,
  output logic                                     out_zero_fill,
  output logic                                     out_last_element
);

  localparam int PACK_W = MAX_AXES * AXIS_BITS;

  logic [svaw_pkg::RANK_W-1:0] view_rank_r;
  logic [PACK_W-1:0]           extents_r;
  logic [PACK_W-1:0]           steps_r;
  logic [svaw_pkg::BASE_W-1:0] base_r;
  logic                        win_enable_r;
  logic [PACK_W-1:0]           win_begin_r;
  logic [PACK_W-1:0]           win_end_r;
  logic [MAX_AXES-1:0]         axis_used;
  logic                        s1_take;
  logic                        s1_valid;
  logic [PACK_W-1:0]           s1_coords;
  svaw_pkg::svaw_meta_t        s1_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_rank_r  <= '0;
      extents_r    <= '0;
      steps_r      <= '0;
      base_r       <= '0;
      win_enable_r <= 1'b0;
      win_begin_r  <= '0;
      win_end_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        svaw_pkg::REG_VIEW_RANK:     view_rank_r  <= cfg_data[svaw_pkg::RANK_W-1:0];
        svaw_pkg::REG_AXIS_EXTENTS:  extents_r    <= cfg_data[PACK_W-1:0];
        svaw_pkg::REG_AXIS_STEPS:    steps_r      <= cfg_data[PACK_W-1:0];
        svaw_pkg::REG_BASE_OFFSET:   base_r       <= cfg_data[svaw_pkg::BASE_W-1:0];
        svaw_pkg::REG_WINDOW_ENABLE: win_enable_r <= cfg_data[0];
        svaw_pkg::REG_WINDOW_BEGIN:  win_begin_r  <= cfg_data[PACK_W-1:0];
        svaw_pkg::REG_WINDOW_END:    win_end_r    <= cfg_data[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar d = 0; d < MAX_AXES; d++) begin : g_used
    assign axis_used[d] = view_rank_r > svaw_pkg::RANK_W'(d);
  end

  svaw_stepper #(
    .MAX_AXES  (MAX_AXES),
    .AXIS_BITS (AXIS_BITS)
  ) u_stepper (
    .clk             (clk),
    .rst_n           (rst_n),
    .axis_used       (axis_used),
    .extents         (extents_r),
    .win_enable      (win_enable_r),
    .win_begin       (win_begin_r),
    .win_end         (win_end_r),
    .in_valid        (in_valid),
    .in_restart_walk (in_restart_walk),
    .in_stall        (in_stall),
    .s1_take         (s1_take),
    .s1_valid        (s1_valid),
    .s1_coords       (s1_coords),
    .s1_meta         (s1_meta)
  );

  svaw_source #(
    .MAX_AXES  (MAX_AXES),
    .AXIS_BITS (AXIS_BITS)
  ) u_source (
    .clk                (clk),
    .rst_n              (rst_n),
    .axis_used          (axis_used),
    .steps              (steps_r),
    .base_offset        (base_r),
    .s1_valid           (s1_valid),
    .s1_coords          (s1_coords),
    .s1_meta            (s1_meta),
    .s1_take            (s1_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_element_number (out_element_number),
    .out_source_element (out_source_element),
    .out_zero_fill      (out_zero_fill),
    .out_last_element   (out_last_element)
  );

endmodule
`default_nettype wire

[hdl/svaw_stepper.sv]
// Walk state, coordinate advance, window test and the first pipeline register.
`default_nettype none
module svaw_stepper #(
  parameter int MAX_AXES  = 4,
  parameter int AXIS_BITS = 13
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [MAX_AXES-1:0]               axis_used,
  input  wire logic [MAX_AXES*AXIS_BITS-1:0]     extents,
  input  wire logic                              win_enable,
  input  wire logic [MAX_AXES*AXIS_BITS-1:0]     win_begin,
  input  wire logic [MAX_AXES*AXIS_BITS-1:0]     win_end,
  input  wire logic                              in_valid,
  input  wire logic                              in_restart_walk,
  output logic                                   in_stall,
  input  wire logic                              s1_take,
  output logic                                   s1_valid,
  output logic [MAX_AXES*AXIS_BITS-1:0]          s1_coords,
  output svaw_pkg::svaw_meta_t                   s1_meta
);

  localparam int AB = AXIS_BITS;

  logic [MAX_AXES*AB-1:0]      coords_r;
  logic [MAX_AXES*AB-1:0]      coords_eff;
  logic [MAX_AXES*AB-1:0]      coords_nxt;
  logic [svaw_pkg::FLAT_W-1:0] flat_r;
  logic [svaw_pkg::FLAT_W-1:0] flat_eff;
  logic                        started_r;
  logic                        s1_valid_r;
  logic [MAX_AXES*AB-1:0]      s1_coords_r;
  svaw_pkg::svaw_meta_t        s1_meta_r;
  logic [MAX_AXES-1:0]         wrap;
  logic [MAX_AXES-1:0]         empty_axis;
  logic [MAX_AXES-1:0]         fill_axis;
  logic [MAX_AXES:0]           carry;
  logic                        start;
  logic                        accept;
  logic                        empty;
  logic                        fill;
  logic                        last;

  assign start    = in_restart_walk || !started_r;
  assign accept   = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !s1_take;

  assign coords_eff = start ? '0 : coords_r;
  assign flat_eff   = start ? '0 : flat_r;

  assign carry[MAX_AXES] = 1'b1;

  for (genvar d = 0; d < MAX_AXES; d++) begin : g_axis
    logic [AB-1:0] c;
    logic [AB-1:0] ext;
    logic [AB:0]   inc;
    assign c   = coords_eff[d*AB +: AB];
    assign ext = extents[d*AB +: AB];
    assign inc = {1'b0, c} + {{AB{1'b0}}, 1'b1};
    assign wrap[d]       = !axis_used[d] || (inc >= {1'b0, ext});
    assign carry[d]      = carry[d+1] && wrap[d];
    assign empty_axis[d] = axis_used[d] && (ext == '0);
    assign fill_axis[d]  = axis_used[d] &&
                           ((c < win_begin[d*AB +: AB]) || (c >= win_end[d*AB +: AB]));
    assign coords_nxt[d*AB +: AB] = (axis_used[d] && carry[d+1]) ?
                                    (wrap[d] ? '0 : inc[AB-1:0]) : c;
  end

  assign empty = |empty_axis;
  assign fill  = win_enable && (|fill_axis);
  assign last  = carry[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coords_r   <= '0;
      flat_r     <= '0;
      started_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= !empty;
      if (empty) begin
        coords_r  <= coords_eff;
        flat_r    <= flat_eff;
        started_r <= 1'b1;
      end else begin
        coords_r  <= coords_nxt;
        flat_r    <= last ? flat_eff : flat_eff + 1'b1;
        started_r <= !last;
      end
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !empty) begin
      s1_coords_r    <= coords_eff;
      s1_meta_r.flat <= flat_eff;
      s1_meta_r.fill <= fill;
      s1_meta_r.last <= last;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign s1_coords = s1_coords_r;
  assign s1_meta   = s1_meta_r;

endmodule
`default_nettype wire

[hdl/svaw_source.sv]
// Stride products, source index sum and the result register.
`default_nettype none
module svaw_source #(
  parameter int MAX_AXES  = 4,
  parameter int AXIS_BITS = 13
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [MAX_AXES-1:0]                 axis_used,
  input  wire logic [MAX_AXES*AXIS_BITS-1:0]       steps,
  input  wire logic [svaw_pkg::BASE_W-1:0]         base_offset,
  input  wire logic                                s1_valid,
  input  wire logic [MAX_AXES*AXIS_BITS-1:0]       s1_coords,
  input  wire svaw_pkg::svaw_meta_t                s1_meta,
  output logic                                     s1_take,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [svaw_pkg::FLAT_W-1:0]              out_element_number,
  output logic [svaw_pkg::SRC_W-1:0]               out_source_element,
  output logic                                     out_zero_fill,
  output logic                                     out_last_element
);

  localparam int AB = AXIS_BITS;
  localparam int PW = 2 * AXIS_BITS;

  logic [MAX_AXES*PW-1:0]     prod_r;
  svaw_pkg::svaw_meta_t       s2_meta_r;
  logic                       s2_valid_r;
  logic                       out_valid_r;
  logic                       out_free;
  logic                       s2_free;
  logic [svaw_pkg::SRC_W-1:0] src_sum;
  svaw_pkg::svaw_meta_t       out_meta_r;
  logic [svaw_pkg::SRC_W-1:0] out_src_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_take  = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_r <= s1_valid;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      for (int d = 0; d < MAX_AXES; d++) begin
        prod_r[d*PW +: PW] <= axis_used[d] ?
                              PW'(s1_coords[d*AB +: AB]) * PW'(steps[d*AB +: AB]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_meta_r <= s1_meta;
    end
  end

  always_comb begin
    src_sum = svaw_pkg::SRC_W'(base_offset);
    for (int d = 0; d < MAX_AXES; d++) begin
      src_sum = src_sum + svaw_pkg::SRC_W'(prod_r[d*PW +: PW]);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_free) begin
      out_meta_r <= s2_meta_r;
      out_src_r  <= src_sum;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_element_number = out_meta_r.flat;
  assign out_source_element = out_src_r;
  assign out_zero_fill      = out_meta_r.fill;
  assign out_last_element   = out_meta_r.last;

endmodule
`default_nettype wire

[hdl/svaw_checker.sv]
// Port-level assertions for the strided view address walker and their binding.
`default_nettype none
module svaw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_element_number,
  input wire logic [31:0] out_source_element,
  input wire logic        out_zero_fill,
  input wire logic        out_last_element
);

  // The pipeline empties on reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The input side backs up only when the result register is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side can move");

  // A stalled element holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element_number) &&
      $stable(out_source_element) && $stable(out_zero_fill) && $stable(out_last_element))
    else $error("stalled element changed");

  // An element after the last one of a walk starts again at element zero.
  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_element ##1 out_valid |->
      out_element_number == 32'd0)
    else $error("walk did not restart at element zero");

endmodule

bind strided_view_address_walker_unit svaw_checker u_svaw_checker (.*);
`default_nettype wire

[test/svaw_walk_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts and compares every element the strided view walker emits.
module svaw_walk_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [svaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svaw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_restart_walk,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [svaw_pkg::FLAT_W-1:0]     out_element_number,
  input  logic [svaw_pkg::SRC_W-1:0]      out_source_element,
  input  logic                            out_zero_fill,
  input  logic                            out_last_element,
  output int                              failures,
  output int                              pending,
  output int                              elements_checked,
  output int                              fill_count,
  output int                              last_count
);
  import svaw_pkg::*;

  typedef struct packed {
    logic [FLAT_W-1:0] number;
    logic [SRC_W-1:0]  source;
    logic              fill;
    logic              last;
  } element_t;

  element_t              expected_elements[$];
  logic [RANK_W-1:0]     rank_reg;
  logic [CFG_DATA_W-1:0] extents_reg;
  logic [CFG_DATA_W-1:0] steps_reg;
  logic [CFG_DATA_W-1:0] begin_reg;
  logic [CFG_DATA_W-1:0] end_reg;
  logic [BASE_W-1:0]     base_reg;
  logic                  window_on;
  logic [12:0]           coord[4];
  logic [FLAT_W-1:0]     flat_pos;
  logic                  walking;

  function automatic logic [12:0] lane(input logic [CFG_DATA_W-1:0] vec, input int d);
    return vec[13*d +: 13];
  endfunction

  function automatic void predict_step(input logic restart);
    int          rank;
    logic [31:0] src;
    logic        fill;
    logic        carry;
    logic        empty;
    element_t    e;
    rank = (rank_reg > 4) ? 4 : int'(rank_reg);
    if (restart || !walking) begin
      for (int d = 0; d < 4; d++) coord[d] = '0;
      flat_pos = '0;
      walking = 1'b1;
    end
    empty = 1'b0;
    for (int d = 0; d < rank; d++) begin
      if (lane(extents_reg, d) == 13'd0) empty = 1'b1;
    end
    if (empty) return;
    src = 32'(base_reg);
    fill = 1'b0;
    for (int d = 0; d < rank; d++) begin
      src = src + 32'(coord[d]) * 32'(lane(steps_reg, d));
      if (window_on && (coord[d] < lane(begin_reg, d) || coord[d] >= lane(end_reg, d)))
        fill = 1'b1;
    end
    carry = 1'b1;
    for (int d = rank - 1; d >= 0 && carry; d--) begin
      if (32'(coord[d]) + 32'd1 >= 32'(lane(extents_reg, d))) begin
        coord[d] = '0;
      end else begin
        coord[d] = coord[d] + 13'd1;
        carry = 1'b0;
      end
    end
    e.number = flat_pos;
    e.source = src;
    e.fill = fill;
    e.last = carry;
    expected_elements.push_back(e);
    if (carry) walking = 1'b0;
    else flat_pos = flat_pos + 32'd1;
  endfunction

  always @(posedge clk) begin : watch_channels
    element_t e;
    if (!rst_n) begin
      rank_reg = '0;
      extents_reg = '0;
      steps_reg = '0;
      begin_reg = '0;
      end_reg = '0;
      base_reg = '0;
      window_on = 1'b0;
      for (int d = 0; d < 4; d++) coord[d] = '0;
      flat_pos = '0;
      walking = 1'b0;
      expected_elements.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VIEW_RANK:     rank_reg = cfg_data[RANK_W-1:0];
          REG_AXIS_EXTENTS:  extents_reg = cfg_data;
          REG_AXIS_STEPS:    steps_reg = cfg_data;
          REG_BASE_OFFSET:   base_reg = cfg_data[BASE_W-1:0];
          REG_WINDOW_ENABLE: window_on = cfg_data[0];
          REG_WINDOW_BEGIN:  begin_reg = cfg_data;
          REG_WINDOW_END:    end_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_step(in_restart_walk);
      if (out_valid && !out_stall) begin
        if (expected_elements.size() == 0) begin
          $error("element %0d arrived with no step item waiting", out_element_number);
          failures++;
        end else begin
          e = expected_elements.pop_front();
          if (out_element_number !== e.number) begin
            $error("element_number: expected %0d, got %0d", e.number, out_element_number);
            failures++;
          end
          if (out_source_element !== e.source) begin
            $error("source_element: expected %0d, got %0d", e.source, out_source_element);
            failures++;
          end
          if (out_zero_fill !== e.fill) begin
            $error("zero_fill: expected %0b, got %0b", e.fill, out_zero_fill);
            failures++;
          end
          if (out_last_element !== e.last) begin
            $error("last_element: expected %0b, got %0b", e.last, out_last_element);
            failures++;
          end
          elements_checked++;
          if (e.fill) fill_count++;
          if (e.last) last_count++;
        end
      end
    end
    pending = expected_elements.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the strided view walker: clock, reset, stimulus and verdict.
module tb;
  import svaw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASES       = 36;
  localparam int PHASE_ITEMS  = 25;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart_walk = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FLAT_W-1:0]     out_element_number;
  logic [SRC_W-1:0]      out_source_element;
  logic                  out_zero_fill;
  logic                  out_last_element;

  int failures;
  int pending;
  int elements_checked;
  int fill_count;
  int last_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int cycles = 0;
  int steps_sent = 0;
  int settings_used = 0;

  strided_view_address_walker_unit uut (.*);
  svaw_walk_checker walk_check (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pack4(input int a0, input int a1,
                                                  input int a2, input int a3);
    return {13'(a3), 13'(a2), 13'(a1), 13'(a0)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_lanes(input int lo, input int hi,
                                                         input int top_pct);
    logic [CFG_DATA_W-1:0] v;
    for (int d = 0; d < 4; d++)
      v[13*d +: 13] = ($urandom_range(99) < top_pct) ? 13'd8191 : 13'($urandom_range(hi, lo));
    return v;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_step(input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart_walk <= restart;
    do @(posedge clk); while (in_stall);
    steps_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lanes;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rank zero after reset gives each step a single last element at the origin.
    send_step(1'b0);
    send_step(1'b1);
    drain();
    write_reg(REG_BASE_OFFSET, 52'hFFFFFF);
    settings_used++;
    send_step(1'b0);
    drain();

    // An axis in use with extent zero yields nothing.
    write_reg(REG_VIEW_RANK, 52'd1);
    write_reg(REG_AXIS_EXTENTS, pack4(0, 0, 0, 0));
    settings_used++;
    send_step(1'b0);
    send_step(1'b1);
    drain();

    write_reg(REG_AXIS_EXTENTS, pack4(8191, 0, 0, 0));
    write_reg(REG_AXIS_STEPS, pack4(8191, 0, 0, 0));
    write_reg(REG_WINDOW_ENABLE, 52'd1);
    write_reg(REG_WINDOW_BEGIN, pack4(1, 0, 0, 0));
    write_reg(REG_WINDOW_END, pack4(8191, 0, 0, 0));
    settings_used++;
    repeat (3) send_step(1'b0);
    drain();

    // Two axes, a full wrap of the walk and a restart in the middle.
    write_reg(REG_VIEW_RANK, 52'd2);
    write_reg(REG_AXIS_EXTENTS, pack4(2, 3, 0, 0));
    write_reg(REG_AXIS_STEPS, pack4(5, 0, 0, 0));
    write_reg(REG_BASE_OFFSET, 52'd7);
    write_reg(REG_WINDOW_BEGIN, pack4(0, 1, 0, 0));
    write_reg(REG_WINDOW_END, pack4(2, 2, 0, 0));
    settings_used++;
    repeat (7) send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    drain();

    // Rank above the axis count acts as four axes; the walk above is left mid-way.
    write_reg(REG_VIEW_RANK, 52'd7);
    write_reg(REG_AXIS_EXTENTS, pack4(1, 2, 1, 2));
    write_reg(REG_AXIS_STEPS, pack4(1, 2, 3, 4));
    write_reg(REG_WINDOW_ENABLE, 52'd0);
    settings_used++;
    repeat (5) send_step(1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_VIEW_RANK, 52'($urandom_range(7)));
      if (phase == 0 || $urandom_range(9) < 7) begin
        lanes = random_lanes(1, 4, 5);
        if ($urandom_range(29) == 0) lanes[13*$urandom_range(3) +: 13] = '0;
        write_reg(REG_AXIS_EXTENTS, lanes);
      end
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_AXIS_STEPS, random_lanes(0, 8191, 10));
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_BASE_OFFSET,
                  ($urandom_range(9) == 0) ? 52'hFFFFFF : 52'($urandom_range(24'hFFFFFF)));
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_WINDOW_ENABLE, 52'($urandom_range(1)));
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_WINDOW_BEGIN, random_lanes(0, 2, 5));
      if (phase == 0 || $urandom_range(9) < 7)
        write_reg(REG_WINDOW_END, random_lanes(0, 5, 5));
      settings_used++;
      if (phase == 4) hold_asked++;
      repeat (PHASE_ITEMS) send_step($urandom_range(99) < 4);
    end

    drain();
    $display("Walked %0d elements from %0d step items: %0d zero-filled, %0d view ends.",
             elements_checked, steps_sent, fill_count, last_count);
    $display("Covered %0d register settings with ranks 0 to 7, idle and stall mixes.",
             settings_used);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
